[sv/tpcf_pkg.sv]
// Shared constants, status codes and helpers for the three-point circle fit.
// No dependencies; imported by every module of the block.
`default_nettype none

package tpcf_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int STATUS_W        = 2;

  typedef logic [STATUS_W-1:0] fit_status_t;

  localparam fit_status_t ST_OK         = 2'd0;
  localparam fit_status_t ST_COLLINEAR  = 2'd1;
  localparam fit_status_t ST_NEG_RADIUS = 2'd2;
  localparam fit_status_t ST_SATURATED  = 2'd3;

  // Elaboration-time width helper
  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[sv/tpcf_div.sv]
// Pipelined restoring divider: one quotient bit per stage, plus an overflow
// flag when the quotient does not fit QB bits. Depends on tpcf_pkg.
`default_nettype none

module tpcf_div #(
  parameter int NUMW = 8,
  parameter int DVW  = 8,
  parameter int QB   = 4,
  parameter int PW   = 1
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [NUMW-1:0] in_num,
  input  wire logic [DVW-1:0]  in_dv,
  input  wire logic [PW-1:0]   in_pay,
  output logic                 out_valid,
  output logic [QB-1:0]        out_quo,
  output logic                 out_ovf,
  output logic [PW-1:0]        out_pay
);
  import tpcf_pkg::*;

  localparam int TW = NUMW - QB;
  localparam int CW = max_int(TW, DVW) + 1;

  logic [QB:0]     vld_r;
  logic [DVW-1:0]  rem_r [0:QB];
  logic [DVW-1:0]  dv_r  [0:QB];
  logic [QB-1:0]   low_r [0:QB];
  logic [QB-1:0]   quo_r [0:QB];
  logic            ovf_r [0:QB];
  logic [PW-1:0]   pay_r [0:QB];

  // Advance valid bits every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[QB-1:0], in_valid};
    end
  end

  // Check for quotient overflow and seed the remainder
  always_ff @(posedge clk) begin
    rem_r[0] <= DVW'(in_num[NUMW-1:QB]);
    ovf_r[0] <= CW'(in_num[NUMW-1:QB]) >= CW'(in_dv);
    low_r[0] <= in_num[QB-1:0];
    dv_r[0]  <= in_dv;
    quo_r[0] <= '0;
    pay_r[0] <= in_pay;
  end

  // One quotient bit per stage
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [DVW:0]   trial;
    logic           ge;
    logic [DVW:0]   diff;

    always_comb begin
      trial = {rem_r[k-1], low_r[k-1][QB-1]};
      ge    = trial >= {1'b0, dv_r[k-1]};
      diff  = trial - {1'b0, dv_r[k-1]};
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
      quo_r[k] <= {quo_r[k-1][QB-2:0], ge};
      low_r[k] <= {low_r[k-1][QB-2:0], 1'b0};
      dv_r[k]  <= dv_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
      pay_r[k] <= pay_r[k-1];
    end
  end

  assign out_valid = vld_r[QB];
  assign out_quo   = quo_r[QB];
  assign out_ovf   = ovf_r[QB];
  assign out_pay   = pay_r[QB];

endmodule

`default_nettype wire

[sv/tpcf_sqrt.sv]
// Pipelined restoring integer square root: one root bit per stage.
// Depends on tpcf_pkg.
`default_nettype none

module tpcf_sqrt #(
  parameter int RADW = 16,
  parameter int PW   = 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [RADW-1:0]   in_rad,
  input  wire logic [PW-1:0]     in_pay,
  output logic                   out_valid,
  output logic [RADW/2-1:0]      out_root,
  output logic [PW-1:0]          out_pay
);
  import tpcf_pkg::*;

  localparam int RTW = RADW / 2;
  localparam int RMW = RTW + 2;

  logic [RTW-1:0]  vld_r;
  logic [RTW-1:0]  root_r [0:RTW-1];
  logic [RMW-1:0]  rem_r  [0:RTW-1];
  logic [RADW-1:0] rad_r  [0:RTW-1];
  logic [PW-1:0]   pay_r  [0:RTW-1];

  // Advance valid bits every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[RTW-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < RTW; k++) begin : g_step
    logic [RTW-1:0]  root_i;
    logic [RMW-1:0]  rem_i;
    logic [RADW-1:0] rad_i;
    logic [PW-1:0]   pay_i;
    logic [RMW+1:0]  cur;
    logic [RMW+1:0]  trial;
    logic [RMW+1:0]  diff;
    logic            ge;

    // Source of this stage: ports for the first, previous stage otherwise
    if (k == 0) begin : g_first
      assign root_i = '0;
      assign rem_i  = '0;
      assign rad_i  = in_rad;
      assign pay_i  = in_pay;
    end else begin : g_next
      assign root_i = root_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign rad_i  = rad_r[k-1];
      assign pay_i  = pay_r[k-1];
    end

    // Bring down two radicand bits, try root*4+1
    always_comb begin
      cur   = {rem_i, rad_i[RADW-1 -: 2]};
      trial = (RMW+2)'({root_i, 2'b01});
      ge    = cur >= trial;
      diff  = cur - trial;
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? diff[RMW-1:0] : cur[RMW-1:0];
      root_r[k] <= {root_i[RTW-2:0], ge};
      rad_r[k]  <= {rad_i[RADW-3:0], 2'b00};
      pay_r[k]  <= pay_i;
    end
  end

  assign out_valid = vld_r[RTW-1];
  assign out_root  = root_r[RTW-1];
  assign out_pay   = pay_r[RTW-1];

endmodule

`default_nettype wire

[sv/three_point_circle_fit.sv]
// Throughput: one transaction per cycle; busy is held low, every stage advances
// each cycle. Latency is set by the root pipeline (3*COORD_WIDTH+3 stages) and
// the two divider pipelines (one quotient bit per stage each).
// Reset (synchronous, rst_n low) clears the valid bits; data registers keep going.
// Top level of the circle fit; depends on tpcf_pkg, tpcf_div and tpcf_sqrt.
`default_nettype none

module three_point_circle_fit #(
  parameter int COORD_WIDTH = tpcf_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_b_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_c_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_c_y,
  output logic                               out_valid,
  output logic signed [COORD_WIDTH-1:0]      out_center_x,
  output logic signed [COORD_WIDTH-1:0]      out_center_y,
  output logic [COORD_WIDTH-1:0]             out_radius,
  output tpcf_pkg::fit_status_t              out_fit_status
);
  import tpcf_pkg::*;

  localparam int W    = COORD_WIDTH;
  localparam int DW   = W + 1;       // point deltas, also chunk width
  localparam int PW   = 2 * W + 2;   // delta products
  localparam int SW   = 2 * W + 2;   // squared chord lengths
  localparam int DETW = 2 * W + 3;   // determinant
  localparam int CPW  = 2 * W + 3;   // signed delta times length chunk
  localparam int NW   = 3 * W + 4;   // centre numerators
  localparam int MW   = 3 * DW;      // numerator magnitude
  localparam int ADW  = 2 * W + 3;   // |2*det|
  localparam int NUMW = 3 * W + 5;   // rounding dividend
  localparam int DVW  = 2 * W + 4;   // rounding divisor
  localparam int QCW  = W + 1;       // centre offset quotient
  localparam int CSW  = 2 * W + 5;   // column sums of the square
  localparam int SQW  = 6 * W + 6;   // squared radius numerator
  localparam int RW   = SQW / 2;     // its root
  localparam int CTW  = W + 3;       // unclamped centre
  localparam int LAT  = 5 * W + 18;

  localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic                qneg_x;
    logic                col;
    logic signed [W-1:0] x1;
    logic signed [W-1:0] y1;
    logic [ADW-1:0]      ad;
    logic [MW-1:0]       mag_x;
    logic [MW-1:0]       mag_y;
  } cdiv_pay_t;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic                satc;
    logic                col;
    logic [ADW-1:0]      ad;
  } sq_pay_t;

  typedef struct packed {
    logic signed [W-1:0] cx;
    logic signed [W-1:0] cy;
    logic                satc;
    logic                col;
  } rd_pay_t;

  // Round-away quotient applied to the base point, then clamp: {sat, value}
  function automatic logic [W:0] clamp_coord(input logic signed [W-1:0] base,
                                             input logic [QCW-1:0] quo,
                                             input logic qneg,
                                             input logic ovf);
    logic signed [CTW-1:0] qs;
    logic signed [CTW-1:0] sum;
    logic                  sat;
    logic signed [W-1:0]   val;
    qs  = $signed(CTW'(quo));
    if (qneg) qs = -qs;
    sum = CTW'(base) + qs;
    sat = 1'b1;
    if (ovf) begin
      val = qneg ? CMIN : CMAX;
    end else if (sum > CTW'(CMAX)) begin
      val = CMAX;
    end else if (sum < CTW'(CMIN)) begin
      val = CMIN;
    end else begin
      sat = 1'b0;
      val = sum[W-1:0];
    end
    return {sat, val};
  endfunction

  // Fully pipelined: never back-pressure the sender
  assign busy = 1'b0;

  logic [6:0] va_r;
  logic [3:0] vb_r;
  logic       cdx_v, cdy_v, sq_v, rd_v;

  // Advance front and middle valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= '0;
      vb_r <= '0;
    end else begin
      va_r <= {va_r[5:0], start && !busy};
      vb_r <= {vb_r[2:0], cdx_v && cdy_v};
    end
  end

  // p0: deltas from point A
  logic signed [DW-1:0] p0_u2_r, p0_v2_r, p0_u3_r, p0_v3_r;
  logic signed [W-1:0]  p0_x1_r, p0_y1_r;

  always_ff @(posedge clk) begin
    p0_u2_r <= DW'(in_point_b_x) - DW'(in_point_a_x);
    p0_v2_r <= DW'(in_point_b_y) - DW'(in_point_a_y);
    p0_u3_r <= DW'(in_point_c_x) - DW'(in_point_a_x);
    p0_v3_r <= DW'(in_point_c_y) - DW'(in_point_a_y);
    p0_x1_r <= in_point_a_x;
    p0_y1_r <= in_point_a_y;
  end

  // p1: delta products
  logic signed [PW-1:0] p1_uu2_r, p1_vv2_r, p1_uu3_r, p1_vv3_r, p1_u2v3_r, p1_u3v2_r;
  logic signed [DW-1:0] p1_u2_r, p1_v2_r, p1_u3_r, p1_v3_r;
  logic signed [W-1:0]  p1_x1_r, p1_y1_r;

  always_ff @(posedge clk) begin
    p1_uu2_r  <= PW'(p0_u2_r * p0_u2_r);
    p1_vv2_r  <= PW'(p0_v2_r * p0_v2_r);
    p1_uu3_r  <= PW'(p0_u3_r * p0_u3_r);
    p1_vv3_r  <= PW'(p0_v3_r * p0_v3_r);
    p1_u2v3_r <= PW'(p0_u2_r * p0_v3_r);
    p1_u3v2_r <= PW'(p0_u3_r * p0_v2_r);
    p1_u2_r   <= p0_u2_r;
    p1_v2_r   <= p0_v2_r;
    p1_u3_r   <= p0_u3_r;
    p1_v3_r   <= p0_v3_r;
    p1_x1_r   <= p0_x1_r;
    p1_y1_r   <= p0_y1_r;
  end

  // p2: squared chord lengths and determinant
  logic [SW-1:0]          p2_s2_r, p2_s3_r;
  logic signed [DETW-1:0] p2_det_r;
  logic signed [DW-1:0]   p2_u2_r, p2_v2_r, p2_u3_r, p2_v3_r;
  logic signed [W-1:0]    p2_x1_r, p2_y1_r;

  always_ff @(posedge clk) begin
    p2_s2_r  <= SW'(p1_uu2_r + p1_vv2_r);
    p2_s3_r  <= SW'(p1_uu3_r + p1_vv3_r);
    p2_det_r <= DETW'(p1_u2v3_r) - DETW'(p1_u3v2_r);
    p2_u2_r  <= p1_u2_r;
    p2_v2_r  <= p1_v2_r;
    p2_u3_r  <= p1_u3_r;
    p2_v3_r  <= p1_v3_r;
    p2_x1_r  <= p1_x1_r;
    p2_y1_r  <= p1_y1_r;
  end

  // p3: delta times high and low chunks of the lengths
  logic signed [DW:0]      s2h, s2l, s3h, s3l;
  logic signed [CPW-1:0]   p3_v3s2h_r, p3_v3s2l_r, p3_v2s3h_r, p3_v2s3l_r;
  logic signed [CPW-1:0]   p3_u2s3h_r, p3_u2s3l_r, p3_u3s2h_r, p3_u3s2l_r;
  logic signed [DETW-1:0]  p3_det_r;
  logic signed [W-1:0]     p3_x1_r, p3_y1_r;

  always_comb begin
    s2h = $signed({1'b0, p2_s2_r[SW-1:DW]});
    s2l = $signed({1'b0, p2_s2_r[DW-1:0]});
    s3h = $signed({1'b0, p2_s3_r[SW-1:DW]});
    s3l = $signed({1'b0, p2_s3_r[DW-1:0]});
  end

  always_ff @(posedge clk) begin
    p3_v3s2h_r <= CPW'(p2_v3_r * s2h);
    p3_v3s2l_r <= CPW'(p2_v3_r * s2l);
    p3_v2s3h_r <= CPW'(p2_v2_r * s3h);
    p3_v2s3l_r <= CPW'(p2_v2_r * s3l);
    p3_u2s3h_r <= CPW'(p2_u2_r * s3h);
    p3_u2s3l_r <= CPW'(p2_u2_r * s3l);
    p3_u3s2h_r <= CPW'(p2_u3_r * s2h);
    p3_u3s2l_r <= CPW'(p2_u3_r * s2l);
    p3_det_r   <= p2_det_r;
    p3_x1_r    <= p2_x1_r;
    p3_y1_r    <= p2_y1_r;
  end

  // p4: centre numerators, |2*det|, collinear flag
  logic signed [NW-1:0]   nx_hi, ny_hi;
  logic signed [DETW-1:0] det_abs;
  logic signed [NW-1:0]   p4_nx_r, p4_ny_r;
  logic [ADW-1:0]         p4_ad_r;
  logic                   p4_col_r, p4_dneg_r;
  logic signed [W-1:0]    p4_x1_r, p4_y1_r;

  always_comb begin
    nx_hi   = (NW'(p3_v3s2h_r) - NW'(p3_v2s3h_r)) <<< DW;
    ny_hi   = (NW'(p3_u2s3h_r) - NW'(p3_u3s2h_r)) <<< DW;
    det_abs = p3_det_r[DETW-1] ? -p3_det_r : p3_det_r;
  end

  always_ff @(posedge clk) begin
    p4_nx_r   <= nx_hi + NW'(p3_v3s2l_r) - NW'(p3_v2s3l_r);
    p4_ny_r   <= ny_hi + NW'(p3_u2s3l_r) - NW'(p3_u3s2l_r);
    p4_ad_r   <= {det_abs[ADW-2:0], 1'b0};
    p4_col_r  <= (p3_det_r == '0);
    p4_dneg_r <= p3_det_r[DETW-1];
    p4_x1_r   <= p3_x1_r;
    p4_y1_r   <= p3_y1_r;
  end

  // p5: numerator magnitudes and signs
  logic signed [NW-1:0] nx_abs, ny_abs;
  logic [MW-1:0]        p5_magx_r, p5_magy_r;
  logic                 p5_qnegx_r, p5_qnegy_r, p5_col_r;
  logic [ADW-1:0]       p5_ad_r;
  logic signed [W-1:0]  p5_x1_r, p5_y1_r;

  always_comb begin
    nx_abs = p4_nx_r[NW-1] ? -p4_nx_r : p4_nx_r;
    ny_abs = p4_ny_r[NW-1] ? -p4_ny_r : p4_ny_r;
  end

  always_ff @(posedge clk) begin
    p5_magx_r  <= nx_abs[MW-1:0];
    p5_magy_r  <= ny_abs[MW-1:0];
    p5_qnegx_r <= p4_nx_r[NW-1] ^ p4_dneg_r;
    p5_qnegy_r <= p4_ny_r[NW-1] ^ p4_dneg_r;
    p5_col_r   <= p4_col_r;
    p5_ad_r    <= p4_ad_r;
    p5_x1_r    <= p4_x1_r;
    p5_y1_r    <= p4_y1_r;
  end

  // p6: rounding dividends 2|n| + |d2| over divisor 2|d2|
  logic [NUMW-1:0] p6_numx_r, p6_numy_r;
  logic [DVW-1:0]  p6_dv_r;
  cdiv_pay_t       p6_pay_r;
  logic            p6_qnegy_r;

  always_ff @(posedge clk) begin
    p6_numx_r       <= (NUMW'(p5_magx_r) << 1) + NUMW'(p5_ad_r);
    p6_numy_r       <= (NUMW'(p5_magy_r) << 1) + NUMW'(p5_ad_r);
    p6_dv_r         <= {p5_ad_r, 1'b0};
    p6_pay_r.qneg_x <= p5_qnegx_r;
    p6_pay_r.col    <= p5_col_r;
    p6_pay_r.x1     <= p5_x1_r;
    p6_pay_r.y1     <= p5_y1_r;
    p6_pay_r.ad     <= p5_ad_r;
    p6_pay_r.mag_x  <= p5_magx_r;
    p6_pay_r.mag_y  <= p5_magy_r;
    p6_qnegy_r      <= p5_qnegy_r;
  end

  // Centre offset dividers
  logic [QCW-1:0] qx, qy;
  logic           ovfx, ovfy;
  cdiv_pay_t      cd_pay;
  logic           cd_qnegy;

  tpcf_div #(
    .NUMW (NUMW),
    .DVW  (DVW),
    .QB   (QCW),
    .PW   ($bits(cdiv_pay_t))
  ) u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (va_r[6]),
    .in_num    (p6_numx_r),
    .in_dv     (p6_dv_r),
    .in_pay    (p6_pay_r),
    .out_valid (cdx_v),
    .out_quo   (qx),
    .out_ovf   (ovfx),
    .out_pay   (cd_pay)
  );

  tpcf_div #(
    .NUMW (NUMW),
    .DVW  (DVW),
    .QB   (QCW),
    .PW   (1)
  ) u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (va_r[6]),
    .in_num    (p6_numy_r),
    .in_dv     (p6_dv_r),
    .in_pay    (p6_qnegy_r),
    .out_valid (cdy_v),
    .out_quo   (qy),
    .out_ovf   (ovfy),
    .out_pay   (cd_qnegy)
  );

  // p7: clamp centre, chunk products of the numerator squares
  logic [W:0]          clx, cly;
  logic [DW-1:0]       ax0, ax1, ax2, ay0, ay1, ay2;
  logic [PW-1:0]       p7_x00_r, p7_x01_r, p7_x02_r, p7_x11_r, p7_x12_r, p7_x22_r;
  logic [PW-1:0]       p7_y00_r, p7_y01_r, p7_y02_r, p7_y11_r, p7_y12_r, p7_y22_r;
  sq_pay_t             p7_pay_r;

  always_comb begin
    clx = clamp_coord(cd_pay.x1, qx, cd_pay.qneg_x, ovfx);
    cly = clamp_coord(cd_pay.y1, qy, cd_qnegy, ovfy);
    ax0 = cd_pay.mag_x[DW-1:0];
    ax1 = cd_pay.mag_x[2*DW-1:DW];
    ax2 = cd_pay.mag_x[3*DW-1:2*DW];
    ay0 = cd_pay.mag_y[DW-1:0];
    ay1 = cd_pay.mag_y[2*DW-1:DW];
    ay2 = cd_pay.mag_y[3*DW-1:2*DW];
  end

  always_ff @(posedge clk) begin
    p7_x00_r      <= PW'(ax0 * ax0);
    p7_x01_r      <= PW'(ax0 * ax1);
    p7_x02_r      <= PW'(ax0 * ax2);
    p7_x11_r      <= PW'(ax1 * ax1);
    p7_x12_r      <= PW'(ax1 * ax2);
    p7_x22_r      <= PW'(ax2 * ax2);
    p7_y00_r      <= PW'(ay0 * ay0);
    p7_y01_r      <= PW'(ay0 * ay1);
    p7_y02_r      <= PW'(ay0 * ay2);
    p7_y11_r      <= PW'(ay1 * ay1);
    p7_y12_r      <= PW'(ay1 * ay2);
    p7_y22_r      <= PW'(ay2 * ay2);
    p7_pay_r.cx   <= clx[W-1:0];
    p7_pay_r.cy   <= cly[W-1:0];
    p7_pay_r.satc <= clx[W] | cly[W];
    p7_pay_r.col  <= cd_pay.col;
    p7_pay_r.ad   <= cd_pay.ad;
  end

  // p8: column sums by power of the chunk base
  logic [CSW-1:0] p8_c0_r, p8_c1_r, p8_c2_r, p8_c3_r, p8_c4_r;
  sq_pay_t        p8_pay_r;

  always_ff @(posedge clk) begin
    p8_c0_r  <= CSW'(p7_x00_r) + CSW'(p7_y00_r);
    p8_c1_r  <= (CSW'(p7_x01_r) + CSW'(p7_y01_r)) << 1;
    p8_c2_r  <= CSW'(p7_x11_r) + CSW'(p7_y11_r)
              + ((CSW'(p7_x02_r) + CSW'(p7_y02_r)) << 1);
    p8_c3_r  <= (CSW'(p7_x12_r) + CSW'(p7_y12_r)) << 1;
    p8_c4_r  <= CSW'(p7_x22_r) + CSW'(p7_y22_r);
    p8_pay_r <= p7_pay_r;
  end

  // p9: fold columns into a low and a high partial sum
  logic [SQW-1:0] p9_lo_r, p9_hi_r;
  sq_pay_t        p9_pay_r;

  always_ff @(posedge clk) begin
    p9_lo_r  <= SQW'(p8_c0_r) + (SQW'(p8_c1_r) << DW) + (SQW'(p8_c2_r) << (2 * DW));
    p9_hi_r  <= SQW'(p8_c3_r) + (SQW'(p8_c4_r) << DW);
    p9_pay_r <= p8_pay_r;
  end

  // p10: nx^2 + ny^2
  logic [SQW-1:0] p10_sq_r;
  sq_pay_t        p10_pay_r;

  always_ff @(posedge clk) begin
    p10_sq_r  <= p9_lo_r + (p9_hi_r << (3 * DW));
    p10_pay_r <= p9_pay_r;
  end

  // Root of the squared radius numerator
  logic [RW-1:0] root;
  sq_pay_t       sq_pay;
  rd_pay_t       rd_in_pay;

  tpcf_sqrt #(
    .RADW (SQW),
    .PW   ($bits(sq_pay_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vb_r[3]),
    .in_rad    (p10_sq_r),
    .in_pay    (p10_pay_r),
    .out_valid (sq_v),
    .out_root  (root),
    .out_pay   (sq_pay)
  );

  always_comb begin
    rd_in_pay.cx   = sq_pay.cx;
    rd_in_pay.cy   = sq_pay.cy;
    rd_in_pay.satc = sq_pay.satc;
    rd_in_pay.col  = sq_pay.col;
  end

  // floor(root / |d2|), overflow means radius saturates
  logic [W-1:0] rq;
  logic         rovf;
  rd_pay_t      rd_pay;

  tpcf_div #(
    .NUMW (RW),
    .DVW  (ADW),
    .QB   (W),
    .PW   ($bits(rd_pay_t))
  ) u_div_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v),
    .in_num    (root),
    .in_dv     (sq_pay.ad),
    .in_pay    (rd_in_pay),
    .out_valid (rd_v),
    .out_quo   (rq),
    .out_ovf   (rovf),
    .out_pay   (rd_pay)
  );

  // Output register: one-cycle result strobe
  logic                out_valid_r;
  logic signed [W-1:0] out_cx_r, out_cy_r;
  logic [W-1:0]        out_rad_r;
  fit_status_t         out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= rd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pay.col) begin
      out_cx_r  <= '0;
      out_cy_r  <= '0;
      out_rad_r <= '0;
      out_st_r  <= ST_COLLINEAR;
    end else begin
      out_cx_r  <= rd_pay.cx;
      out_cy_r  <= rd_pay.cy;
      out_rad_r <= rovf ? '1 : rq;
      out_st_r  <= (rd_pay.satc || rovf) ? ST_SATURATED : ST_OK;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_center_x   = out_cx_r;
  assign out_center_y   = out_cy_r;
  assign out_radius     = out_rad_r;
  assign out_fit_status = out_st_r;

  // Every accepted transaction yields its result after the fixed latency
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result missing after accepted transaction");

  // No result without an earlier accepted transaction
  a_no_spurious : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without matching transaction");

  // Collinear results carry zero geometry
  a_collinear_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fit_status == ST_COLLINEAR) |->
      (out_center_x == '0 && out_center_y == '0 && out_radius == '0))
    else $error("collinear result with nonzero fields");

  // Saturation shows up as a field at a range end
  a_sat_extreme : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_fit_status == ST_SATURATED) |->
      (out_radius == '1 || out_center_x == CMAX || out_center_x == CMIN ||
       out_center_y == CMAX || out_center_y == CMIN))
    else $error("saturated status with no clamped field");

endmodule

`default_nettype wire

[bench/tb_three_point_circle_fit.sv]
// Self-checking bench for three_point_circle_fit: directed and random point triples.
// Depends on tpcf_pkg and the three_point_circle_fit RTL; the predictor uses exact wide math.
`default_nettype none

module tb_three_point_circle_fit;
  timeunit 1ns;
  timeprecision 1ps;

  import tpcf_pkg::*;

  localparam int CW        = 24;
  localparam int DRAIN_CYC = 5 * CW + 18 + 50;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [255:0]  wide_t;

  typedef struct packed {
    coord_t ax, ay, bx, by, cx, cy;
  } triple_t;

  typedef struct packed {
    coord_t        center_x;
    coord_t        center_y;
    logic [CW-1:0] radius;
    fit_status_t   status;
  } fit_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  coord_t in_point_a_x, in_point_a_y, in_point_b_x, in_point_b_y;
  coord_t in_point_c_x, in_point_c_y;
  logic out_valid;
  coord_t out_center_x, out_center_y;
  logic [CW-1:0] out_radius;
  fit_status_t out_fit_status;

  fit_t expected_fits[$];
  int   mismatch_count;
  bit   no_idle;

  three_point_circle_fit #(.COORD_WIDTH(CW)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_point_a_x   (in_point_a_x),
    .in_point_a_y   (in_point_a_y),
    .in_point_b_x   (in_point_b_x),
    .in_point_b_y   (in_point_b_y),
    .in_point_c_x   (in_point_c_x),
    .in_point_c_y   (in_point_c_y),
    .out_valid      (out_valid),
    .out_center_x   (out_center_x),
    .out_center_y   (out_center_y),
    .out_radius     (out_radius),
    .out_fit_status (out_fit_status)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Round base + n/d2 to nearest (ties away from zero), clamp to coordinate range
  function automatic coord_t round_center(wide_t base, wide_t n, wide_t d2, ref bit sat);
    wide_t an, ad, q, v, hi, lo;
    an = (n < 0) ? -n : n;
    ad = (d2 < 0) ? -d2 : d2;
    q  = (2 * an + ad) / (2 * ad);
    if ((n < 0) != (d2 < 0)) q = -q;
    v  = base + q;
    hi = (wide_t'(1) <<< (CW - 1)) - 1;
    lo = -(wide_t'(1) <<< (CW - 1));
    if (v > hi) begin
      sat = 1'b1;
      v = hi;
    end else if (v < lo) begin
      sat = 1'b1;
      v = lo;
    end
    return v[CW-1:0];
  endfunction

  // Circle through three points in exact integer arithmetic
  function automatic fit_t fit_circle(triple_t p);
    wide_t x1, y1, u2, v2, u3, v3, s2, s3, det, nx, ny, d2, ad, sq, t, cw;
    bit sat;
    logic [CW-1:0] r;
    fit_t f;
    x1 = p.ax;
    y1 = p.ay;
    u2 = wide_t'(p.bx) - x1;
    v2 = wide_t'(p.by) - y1;
    u3 = wide_t'(p.cx) - x1;
    v3 = wide_t'(p.cy) - y1;
    s2 = u2 * u2 + v2 * v2;
    s3 = u3 * u3 + v3 * v3;
    det = u2 * v3 - u3 * v2;
    f = '0;
    if (det == 0) begin
      f.status = ST_COLLINEAR;
      return f;
    end
    sat = 1'b0;
    nx = v3 * s2 - v2 * s3;
    ny = u2 * s3 - u3 * s2;
    d2 = det + det;
    f.center_x = round_center(x1, nx, d2, sat);
    f.center_y = round_center(y1, ny, d2, sat);
    ad = (d2 < 0) ? -d2 : d2;
    sq = nx * nx + ny * ny;
    t  = (wide_t'(1) <<< CW) * ad;
    r  = '0;
    if (t * t <= sq) begin
      sat = 1'b1;
      r = '1;
    end else begin
      for (int b = CW - 1; b >= 0; b--) begin
        cw = {232'd0, r | (24'd1 << b)};
        t  = cw * ad;
        if (t * t <= sq) r = r | (24'd1 << b);
      end
    end
    f.radius = r;
    f.status = sat ? ST_SATURATED : ST_OK;
    return f;
  endfunction

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (no_idle || k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one triple, hold until accepted, then idle for the given gap
  task automatic send_triple(triple_t p, int gap);
    in_point_a_x <= p.ax;
    in_point_a_y <= p.ay;
    in_point_b_x <= p.bx;
    in_point_b_y <= p.by;
    in_point_c_x <= p.cx;
    in_point_c_y <= p.cy;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    expected_fits.push_back(fit_circle(p));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic coord_t near_coord(coord_t c, int span);
    int v;
    v = int'(c) + $urandom_range(0, 2 * span) - span;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return coord_t'(v);
  endfunction

  task automatic test_directed();
    coord_t mx, mn;
    triple_t list[$];
    mx = 24'sh7FFFFF;
    mn = 24'sh800000;
    list.push_back('{0, 0, 1, 0, 0, 1});           // tie rounding, positive
    list.push_back('{0, 0, -1, 0, 0, -1});         // tie rounding, negative
    list.push_back('{0, 0, 0, 0, 0, 0});           // all points coincide
    list.push_back('{mx, mx, mx, mx, mx, mx});
    list.push_back('{mn, mn, mn, mn, mn, mn});
    list.push_back('{mn, mn, mx, mx, 0, 0});       // collinear across full range
    list.push_back('{mn, 0, mx, 0, 0, 1});         // huge radius, far centre
    list.push_back('{mn, mn, mx, mn, mn, mx});     // right triangle, extreme corners
    list.push_back('{mx, mx, mn, mx, mx, mn});
    list.push_back('{mn, mx, mx, mn, mx, mx});
    list.push_back('{10, 0, -10, 0, 0, 10});       // exact circle
    list.push_back('{3, 4, -3, -4, 5, 0});
    list.push_back('{-1, -1, 1, -1, 0, 2});
    list.push_back('{0, 0, 2, 0, 1, 1});
    list.push_back('{100, 200, 100, 201, 101, 200});
    list.push_back('{mx, 0, mn, 1, 0, mx});
    list.push_back('{0, mn, 1, mn, 0, mn + 24'sd1});
    list.push_back('{mx, mx, mx - 24'sd1, mx, mx, mx - 24'sd1});
    list.push_back('{0, 0, 1, 1, 2, 2});
    list.push_back('{5, 5, 5, 6, 5, 7});
    foreach (list[i]) send_triple(list[i], pick_gap());
  endtask

  task automatic test_random(int count);
    triple_t p;
    int kind, span;
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      p.ax = coord_t'($urandom);
      p.ay = coord_t'($urandom);
      if (kind < 3) begin
        // full-range noise
        p.bx = coord_t'($urandom); p.by = coord_t'($urandom);
        p.cx = coord_t'($urandom); p.cy = coord_t'($urandom);
      end else if (kind < 8) begin
        // local triangle: B and C near A within a random span
        span = 1 << $urandom_range(1, 20);
        p.bx = near_coord(p.ax, span); p.by = near_coord(p.ay, span);
        p.cx = near_coord(p.ax, span); p.cy = near_coord(p.ay, span);
      end else if (kind == 8) begin
        // collinear: A, A+d, A+2d within range
        span = $urandom_range(0, 1000);
        p.ax = near_coord(0, 4000000);
        p.ay = near_coord(0, 4000000);
        p.bx = p.ax + coord_t'($urandom_range(0, 2 * span) - span);
        p.by = p.ay + coord_t'($urandom_range(0, 2 * span) - span);
        p.cx = coord_t'(2 * p.bx - p.ax);
        p.cy = coord_t'(2 * p.by - p.ay);
      end else begin
        // nearly collinear: large radius and centre
        p.bx = near_coord(p.ax, 1000000); p.by = near_coord(p.ay, 1000000);
        p.cx = coord_t'(2 * p.bx - p.ax) + coord_t'($urandom_range(0, 2) - 1);
        p.cy = coord_t'(2 * p.by - p.ay) + coord_t'($urandom_range(0, 2) - 1);
      end
      send_triple(p, pick_gap());
    end
    no_idle = 1'b0;
  endtask

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    fit_t want;
    if (rst_n && out_valid) begin
      if (expected_fits.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: cx=%0d cy=%0d r=%0d st=%0d",
                   out_center_x, out_center_y, out_radius, out_fit_status);
      end else begin
        want = expected_fits.pop_front();
        if (out_center_x !== want.center_x || out_center_y !== want.center_y ||
            out_radius !== want.radius || out_fit_status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp cx=%0d cy=%0d r=%0d st=%0d got cx=%0d cy=%0d r=%0d st=%0d",
                     want.center_x, want.center_y, want.radius, want.status,
                     out_center_x, out_center_y, out_radius, out_fit_status);
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    no_idle = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    {in_point_a_x, in_point_a_y, in_point_b_x, in_point_b_y} = '0;
    {in_point_c_x, in_point_c_y} = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1130);
    start <= 1'b0;
    while (expected_fits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatch_count == 0 && expected_fits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
